/* rtl/lexicographic_fifo_priority_queue_top_assert.svh */
// Assertion macros for the priority queue checker.
`ifndef LEXICOGRAPHIC_FIFO_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define LEXICOGRAPHIC_FIFO_PRIORITY_QUEUE_TOP_ASSERT_SVH

`define LFPQ_ASSERT_IMPL(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`define LFPQ_ASSERT_RST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/lfpq_pkg.sv */
// -----------------------------------------------------------------------------
// lfpq_pkg
// Types and codes shared by the lexicographic priority queue.
// -----------------------------------------------------------------------------
package lfpq_pkg;

   localparam int unsigned KEY_W   = 16;
   localparam int unsigned ENTRY_W = 32;
   localparam int unsigned OCC_W   = 11;

   localparam logic [1:0] MODE_INSERT = 2'd0;
   localparam logic [1:0] MODE_REMOVE = 2'd1;
   localparam logic [1:0] MODE_CLEAR  = 2'd2;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic [1:0]         mode;
      logic [KEY_W-1:0]   key_0;
      logic [KEY_W-1:0]   key_1;
      logic [KEY_W-1:0]   key_2;
      logic [KEY_W-1:0]   key_3;
      logic [ENTRY_W-1:0] entry_in;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [ENTRY_W-1:0] entry_out;
      logic [OCC_W-1:0]   occupancy;
      logic               is_empty;
   } rsp_type;

endpackage

/* rtl/lexicographic_fifo_priority_queue_top.sv */
// -----------------------------------------------------------------------------
// lexicographic_fifo_priority_queue_top
// Stable min-priority queue over lexicographic keys with FIFO tie break.
// -----------------------------------------------------------------------------
// Usage:
//   Request channel: raise start with req_data while busy is low. Insert,
//   remove-minimum and clear each give exactly one response, shown for one
//   cycle on rsp_data with rsp_strobe; the receiver cannot stall it.
//   Configuration: csr_valid/csr_ready write key_count; csr_ready is high
//   while no request is in flight and start is low.
//   Sequence: insert, clear and failed requests go from acceptance to
//   S_RESP and then the registered strobe. A remove scans the held entries
//   with one shared compare unit fed by one memory read port, one entry per
//   cycle, plus a copy of the last entry into the hole.
//   Flow: busy drops the cycle after the strobe, and a new request is taken
//   only after that, so requests never overlap and removes are the slowest.
//   The scan over the store bounds the rate.
//   Reset clears the count, sequence and key_count (to 1); the stores need
//   no clearing pass.
// -----------------------------------------------------------------------------
module lexicographic_fifo_priority_queue_top #(
   parameter int unsigned CAPACITY = 1024,
   parameter int unsigned NUM_KEYS = 4,
   parameter int unsigned KEY_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  lfpq_pkg::req_type req_data,
   output logic              rsp_strobe,
   output lfpq_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_key_count
);
   import lfpq_pkg::*;

   localparam int unsigned AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int unsigned CW   = $clog2(CAPACITY + 1);
   localparam int unsigned KVW  = NUM_KEYS * KEY_BITS;
   localparam int unsigned WORD = KVW + 32 + ENTRY_W;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_RD0   = 7'b0000010,
      S_SCAN  = 7'b0000100,
      S_RDL   = 7'b0001000,
      S_COPY  = 7'b0010000,
      S_DONE  = 7'b0100000,
      S_RESP  = 7'b1000000
   } state_type;

   logic [WORD-1:0] mem [CAPACITY];

   state_type         state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [31:0]       seq_ff, seq_in;
   logic [2:0]        kc_ff;
   logic [CW-1:0]     idx_ff, idx_in;
   logic [AW-1:0]     best_ff, best_in;
   logic [WORD-1:0]   bword_ff, bword_in;
   logic [WORD-1:0]   rd_ff;
   logic [AW-1:0]     rd_addr;
   logic              rd_en;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [WORD-1:0]   wr_data;
   logic              rd_valid_ff;
   logic [AW-1:0]     rd_tag_ff;
   logic [1:0]        status_ff, status_in;
   logic [ENTRY_W-1:0] out_ff, out_in;
   logic              strobe_ff, strobe_in;
   logic [2:0]        nkeys;
   logic [KVW-1:0]    kin;
   logic              cand_first;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      nkeys = kc_ff;
      if (nkeys == 3'd0) begin
         nkeys = 3'd1;
      end
      if (nkeys > 3'(NUM_KEYS)) begin
         nkeys = 3'(NUM_KEYS);
      end
   end

   always_comb begin
      kin = '0;
      for (int k = 0; k < NUM_KEYS; k++) begin
         case (k)
            0: kin[KVW-1-k*KEY_BITS -: KEY_BITS] = KEY_BITS'(req_data.key_0);
            1: kin[KVW-1-k*KEY_BITS -: KEY_BITS] = KEY_BITS'(req_data.key_1);
            2: kin[KVW-1-k*KEY_BITS -: KEY_BITS] = KEY_BITS'(req_data.key_2);
            default: kin[KVW-1-k*KEY_BITS -: KEY_BITS] = KEY_BITS'(req_data.key_3);
         endcase
      end
   end

   // shared compare unit: candidate in rd_ff against best in bword_ff
   always_comb begin
      logic       decided;
      logic [31:0] age_c, age_b;
      logic [KEY_BITS-1:0] kc, kb;
      decided    = 1'b0;
      cand_first = 1'b0;
      for (int k = 0; k < NUM_KEYS; k++) begin
         kc = rd_ff[WORD-1-k*KEY_BITS -: KEY_BITS];
         kb = bword_ff[WORD-1-k*KEY_BITS -: KEY_BITS];
         if (!decided && (3'(k) < nkeys) && (kc != kb)) begin
            decided    = 1'b1;
            cand_first = kc < kb;
         end
      end
      age_c = seq_ff - rd_ff[ENTRY_W +: 32];
      age_b = seq_ff - bword_ff[ENTRY_W +: 32];
      if (!decided) begin
         cand_first = age_c > age_b;
      end
   end

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      seq_in    = seq_ff;
      idx_in    = idx_ff;
      best_in   = best_ff;
      bword_in  = bword_ff;
      status_in = status_ff;
      out_in    = out_ff;
      strobe_in = 1'b0;
      rd_en     = 1'b0;
      rd_addr   = idx_ff[AW-1:0];
      wr_en     = 1'b0;
      wr_addr   = count_ff[AW-1:0];
      wr_data   = {kin, seq_ff, req_data.entry_in};
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               status_in = STATUS_OK;
               out_in    = '0;
               state_in  = S_RESP;
               case (req_data.mode)
                  MODE_INSERT: begin
                     if (count_ff >= CW'(CAPACITY)) begin
                        status_in = STATUS_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + 1'b1;
                        seq_in   = seq_ff + 32'd1;
                     end
                  end
                  MODE_REMOVE: begin
                     if (count_ff == '0) begin
                        status_in = STATUS_EMPTY;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = '0;
                        idx_in   = CW'(1);
                        best_in  = '0;
                        state_in = S_RD0;
                     end
                  end
                  MODE_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_RD0: begin
            bword_in = rd_ff;
            state_in = S_SCAN;
            if (idx_ff < count_ff) begin
               rd_en = 1'b1;
            end
         end
         S_SCAN: begin
            if (rd_valid_ff && cand_first) begin
               bword_in = rd_ff;
               best_in  = rd_tag_ff;
            end
            if (idx_ff < count_ff) begin
               idx_in = idx_ff + 1'b1;
               if (idx_ff + 1'b1 < count_ff) begin
                  rd_en   = 1'b1;
                  rd_addr = AW'(idx_ff + 1'b1);
               end
            end else begin
               rd_en    = 1'b1;
               rd_addr  = AW'(count_ff - 1'b1);
               state_in = S_RDL;
            end
         end
         S_RDL: begin
            out_in   = bword_ff[ENTRY_W-1:0];
            state_in = S_COPY;
         end
         S_COPY: begin
            if (best_ff != AW'(count_ff - 1'b1)) begin
               wr_en   = 1'b1;
               wr_addr = best_ff;
               wr_data = rd_ff;
            end
            count_in = count_ff - 1'b1;
            state_in = S_RESP;
         end
         S_RESP: begin
            strobe_in = 1'b1;
            state_in  = S_DONE;
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         count_ff    <= '0;
         seq_ff      <= '0;
         kc_ff       <= 3'd1;
         strobe_ff   <= 1'b0;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         seq_ff      <= seq_in;
         strobe_ff   <= strobe_in;
         rd_valid_ff <= rd_en && (state_ff == S_RD0 || state_ff == S_SCAN)
                        && (state_in == S_SCAN);
         if (csr_valid && csr_ready) begin
            kc_ff <= csr_key_count;
         end
      end
      idx_ff    <= idx_in;
      best_ff   <= best_in;
      bword_ff  <= bword_in;
      status_ff <= status_in;
      out_ff    <= out_in;
      rd_tag_ff <= rd_addr;
   end

   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = (state_ff == S_IDLE) && !start;
   assign rsp_strobe = strobe_ff;
   assign rsp_data.status    = status_ff;
   assign rsp_data.entry_out = out_ff;
   assign rsp_data.occupancy = OCC_W'(count_ff);
   assign rsp_data.is_empty  = (count_ff == '0);

endmodule

/* rtl/lfpq_checker.sv */
// -----------------------------------------------------------------------------
// lfpq_checker
// Port-level checks on the priority queue's request and response timing and response fields.
// -----------------------------------------------------------------------------
`include "lexicographic_fifo_priority_queue_top_assert.svh"

module lfpq_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_strobe,
   input lfpq_pkg::rsp_type rsp_data
);
   import lfpq_pkg::*;

   `LFPQ_ASSERT_IMPL(a_accept_busy, clock, reset, (start && !busy) |=> busy, "no busy after request")
   `LFPQ_ASSERT_IMPL(a_strobe_busy, clock, reset, rsp_strobe |-> busy, "response outside request")
   `LFPQ_ASSERT_IMPL(a_empty_flag, clock, reset, rsp_strobe |-> (rsp_data.is_empty == (rsp_data.occupancy == '0)), "empty flag mismatch")
   `LFPQ_ASSERT_RST(a_reset_idle, clock, (!reset && $past(reset)) |-> (!busy && !rsp_strobe), "not idle after reset")
   `LFPQ_ASSERT_IMPL(a_entry_zero, clock, reset, (rsp_strobe && rsp_data.status != STATUS_OK) |-> (rsp_data.entry_out == '0), "entry on failed request")

endmodule

bind lexicographic_fifo_priority_queue_top lfpq_checker u_lfpq_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

/* tb/sv/lexicographic_fifo_priority_queue_top_test.sv */
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// lexicographic_fifo_priority_queue_top_test
// Checks the stable min-priority queue against a behavioral queue model.
// Requests come from a queue drained by a clocked driver. A clocked monitor
// compares every strobed response with the oldest prediction. One phase fills
// the store past full, then phases at every key_count setting remove from it.
// -----------------------------------------------------------------------------
module lexicographic_fifo_priority_queue_top_test;
   import lfpq_pkg::*;

   localparam int unsigned DEPTH = 1024;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   logic    clock = 1'b0;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;
   logic    csr_valid;
   logic    csr_ready;
   logic [2:0] csr_key_count;

   lexicographic_fifo_priority_queue_top u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_key_count(csr_key_count)
   );

   typedef struct {
      logic [KEY_W-1:0] keys [4];
      logic [31:0]      seq;
      logic [31:0]      payload;
   } slot_type;

   slot_type  held [$];
   logic [31:0] seq_next;
   logic [2:0]  key_count_now;

   req_type pending_reqs [$];
   rsp_type expected_rsps [$];
   int  errors;
   int  rsp_seen;
   int  removes_hit;
   int  fulls_hit;
   bit  quiet;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic bit served_first(slot_type a, slot_type b, int n);
      for (int i = 0; i < n; i++)
         if (a.keys[i] != b.keys[i]) return a.keys[i] < b.keys[i];
      return (seq_next - a.seq) > (seq_next - b.seq);
   endfunction

   function automatic rsp_type queue_answer(req_type r);
      rsp_type  o;
      slot_type s;
      int n, best;
      o = '0;
      o.status = STATUS_OK;
      case (r.mode)
         MODE_INSERT: begin
            if (held.size() >= DEPTH) begin
               o.status = STATUS_FULL;
            end else begin
               s.keys[0] = r.key_0; s.keys[1] = r.key_1;
               s.keys[2] = r.key_2; s.keys[3] = r.key_3;
               s.seq = seq_next; s.payload = r.entry_in;
               held = {held, s};
               seq_next++;
            end
         end
         MODE_REMOVE: begin
            if (held.size() == 0) begin
               o.status = STATUS_EMPTY;
            end else begin
               n = (key_count_now < 1) ? 1 : (key_count_now > 4) ? 4 : key_count_now;
               best = 0;
               for (int i = 1; i < held.size(); i++)
                  if (served_first(held[i], held[best], n)) best = i;
               o.entry_out = held[best].payload;
               held[best] = held[held.size()-1];
               void'(held.pop_back());
            end
         end
         MODE_CLEAR: held.delete();
         default: ;
      endcase
      o.occupancy = OCC_W'(held.size());
      o.is_empty  = (held.size() == 0);
      return o;
   endfunction

   function automatic logic [15:0] pick_key();
      case ($urandom_range(0, 5))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'($urandom_range(0, 3));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic req_type make_req(logic [1:0] m);
      req_type r;
      r.mode = m;
      r.key_0 = pick_key(); r.key_1 = pick_key();
      r.key_2 = pick_key(); r.key_3 = pick_key();
      r.entry_in = $urandom;
      return r;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         start    <= 1'b0;
         req_data <= '0;
      end else begin
         if (start && !busy) begin
            expected_rsps = {expected_rsps, queue_answer(req_data)};
         end
         if (!(start && busy)) begin
            if (pending_reqs.size() > 0 && (quiet || $urandom_range(0, 99) >= 7)) begin
               req_data <= pending_reqs[0];
               pending_reqs.delete(0);
               start    <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         rsp_seen++;
         if (expected_rsps.size() == 0) begin
            $display("%0t unexpected response %p", $time, rsp_data);
            errors++;
         end else begin
            rsp_type e;
            e = expected_rsps[0];
            expected_rsps.delete(0);
            if (rsp_data !== e) begin
               $display("%0t mismatch expected %p actual %p", $time, e, rsp_data);
               errors++;
            end
            if (e.status == STATUS_FULL) fulls_hit++;
            if (e.entry_out != 0) removes_hit++;
         end
      end
   end

   task automatic write_key_count(logic [2:0] v);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_key_count <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      key_count_now = v;
   endtask

   task automatic drain();
      while (pending_reqs.size() > 0 || start || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   initial begin
      int fill_n;
      reset = 1'b1;
      csr_valid = 1'b0; csr_key_count = 3'd1;
      held.delete(); seq_next = 0; key_count_now = 1;
      errors = 0; rsp_seen = 0; removes_hit = 0; fulls_hit = 0; quiet = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: empty remove, extremes, ties, unused mode, clear
      pending_reqs = {pending_reqs, make_req(MODE_REMOVE)};
      begin
         req_type r;
         r = '0; r.mode = MODE_INSERT; r.entry_in = 32'hFFFF_FFFF;
         r.key_0 = 16'hFFFF; r.key_1 = 16'hFFFF; r.key_2 = 16'hFFFF; r.key_3 = 16'hFFFF;
         pending_reqs = {pending_reqs, r};
         r.key_0 = 16'h0000; r.key_1 = 16'h0000; r.key_2 = 16'h0000; r.key_3 = 16'h0000;
         r.entry_in = 32'h0000_0001;
         pending_reqs = {pending_reqs, r};
         r.entry_in = 32'h0000_0002;
         pending_reqs = {pending_reqs, r};
         r.key_1 = 16'hFFFF; r.entry_in = 32'hA5A5_5A5A;
         pending_reqs = {pending_reqs, r};
      end
      pending_reqs = {pending_reqs, make_req(MODE_UNUSED)};
      repeat (4) pending_reqs = {pending_reqs, make_req(MODE_REMOVE)};
      pending_reqs = {pending_reqs, make_req(MODE_INSERT)};
      pending_reqs = {pending_reqs, make_req(MODE_CLEAR)};
      pending_reqs = {pending_reqs, make_req(MODE_REMOVE)};
      drain();

      // fill past full with few distinct leading keys
      write_key_count(3'd4);
      quiet = 1;
      fill_n = int'(DEPTH) - held.size() + 2;
      for (int i = 0; i < fill_n; i++) begin
         req_type r;
         r = make_req(MODE_INSERT);
         r.key_0 = 16'($urandom_range(0, 1)); r.key_1 = 16'($urandom_range(0, 1));
         pending_reqs = {pending_reqs, r};
      end
      drain();

      // remove from the full store over all key_count settings, out-of-range ones too
      for (int ph = 0; ph < 8; ph++) begin
         write_key_count(ph[2:0]);
         quiet = (ph == 3);
         for (int i = 0; i < 5; i++) begin
            int p;
            p = $urandom_range(0, 99);
            pending_reqs = {pending_reqs, make_req(p < 25 ? MODE_INSERT :
                                                   p < 95 ? MODE_REMOVE : MODE_UNUSED)};
         end
         drain();
      end

      pending_reqs = {pending_reqs, make_req(MODE_CLEAR)};
      pending_reqs = {pending_reqs, make_req(MODE_REMOVE)};
      drain();

      $display("covered %0d responses, %0d removes with payload, %0d dropped inserts",
               rsp_seen, removes_hit, fulls_hit);
      if (errors == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #40ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
